// ----- rtl/core/plve_pkg.sv -----
// Package with the shared types and constants of the posting list delta encoder.
`timescale 1ns / 1ps
`default_nettype none

package plve_pkg;

   localparam int OFFSET_BITS  = 11;
   localparam int OFF_IN_W     = 11;
   localparam int VALUE_W      = 32 + OFFSET_BITS;
   localparam int GROUP_BITS   = 7;
   localparam int MAX_BYTES    = (VALUE_W + GROUP_BITS - 1) / GROUP_BITS;
   localparam int LEN_W        = $clog2(MAX_BYTES + 1);
   localparam int BUDGET_W     = 14;
   localparam int COUNT_W      = 16;
   localparam int FIFO_DEPTH   = 2;
   localparam int FIFO_IDX_W   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

   localparam logic [BUDGET_W-1:0] BUDGET_RESET = BUDGET_W'(256);
   localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_DATA    = 2'd1,
      KIND_PAD     = 2'd2,
      KIND_SUMMARY = 2'd3
   } plve_kind_type;

   typedef struct packed {
      logic [31:0]         block_number;
      logic [OFF_IN_W-1:0] offset_number;
      logic                end_of_list;
   } plve_req_type;

   typedef struct packed {
      plve_kind_type       kind;
      logic [7:0]          data_byte;
      logic [31:0]         first_block;
      logic [OFF_IN_W-1:0] first_offset;
      logic [COUNT_W-1:0]  items_packed;
      logic [BUDGET_W-1:0] bytes_written;
      logic                segment_full;
      logic                order_error;
      logic                last_of_run;
   } plve_rsp_type;

   // One classified request, as handed from the front to the back.
   typedef struct packed {
      logic                header;
      logic [31:0]         first_block;
      logic [OFF_IN_W-1:0] first_offset;
      logic [LEN_W-1:0]    nbytes;
      logic [VALUE_W-1:0]  delta;
      logic                pad;
      logic                summary;
      logic [COUNT_W-1:0]  items;
      logic [BUDGET_W-1:0] bytes;
      logic                full;
      logic                order_error;
   } plve_job_type;

endpackage

`default_nettype wire

// ----- rtl/core/posting_list_delta_varbyte_encoder.sv -----
// Top level of the posting list delta varbyte encoder with its budget register.
// A request is taken in the cycle it arrives whenever the two-entry job queue has room.
// Its results pass through the job queue, the current-job register and the output register.
// The back end gives one result per cycle while the output is not stalled; a request
// causes up to nine results, and one that causes none is not queued.
// Reset is synchronous: the budget returns to 256 and the list state is cleared.
`timescale 1ns / 1ps
`default_nettype none

module posting_list_delta_varbyte_encoder (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire plve_pkg::plve_req_type         req_data,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      plve_pkg::plve_rsp_type         rsp_data,
   input  wire logic                           csr_write_enable,
   input  wire logic [plve_pkg::BUDGET_W-1:0]  csr_write_data
);
   import plve_pkg::*;

   logic [BUDGET_W-1:0] budget_ff;
   logic                fifo_full;
   logic                push;
   plve_job_type        push_job;
   logic                pop;
   logic                head_valid;
   plve_job_type        head_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= BUDGET_RESET;
      end else if (csr_write_enable) begin
         budget_ff <= csr_write_data;
      end
   end

   plve_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .budget    (budget_ff),
      .fifo_full (fifo_full),
      .push      (push),
      .job       (push_job)
   );

   plve_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (fifo_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   plve_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ----- rtl/core/plve_front.sv -----
// Front end: accepts requests, keeps the list state and classifies each request into a job.
`timescale 1ns / 1ps
`default_nettype none

module plve_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire plve_pkg::plve_req_type         req_data,
   input  wire logic [plve_pkg::BUDGET_W-1:0]  budget,
   input  wire logic                           fifo_full,
   output      logic                           push,
   output      plve_pkg::plve_job_type         job
);
   import plve_pkg::*;

   logic [VALUE_W-1:0]  prev_ff, prev_in;
   logic [BUDGET_W-1:0] bytes_used_ff, bytes_used_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                awaiting_ff, awaiting_in;
   logic                full_ff, full_in;

   logic                accept;
   logic [VALUE_W-1:0]  value;
   logic [VALUE_W-1:0]  delta;
   logic [LEN_W-1:0]    len;
   logic [BUDGET_W:0]   need;
   logic                oerr;

   assign req_stall = fifo_full;
   assign accept    = req_valid && !req_stall;
   assign value     = {req_data.block_number, OFFSET_BITS'(req_data.offset_number)};
   assign delta     = value - prev_ff;
   assign need      = {1'b0, bytes_used_ff} + (BUDGET_W + 1)'(len);

   always_comb begin
      len = LEN_W'(1);
      for (int k = 1; k < MAX_BYTES; k++) begin
         if ((delta >> (GROUP_BITS * k)) != '0) begin
            len = LEN_W'(k + 1);
         end
      end
   end

   always_comb begin
      prev_in       = prev_ff;
      bytes_used_in = bytes_used_ff;
      count_in      = count_ff;
      awaiting_in   = awaiting_ff;
      full_in       = full_ff;
      oerr          = 1'b0;
      job           = '0;
      job.first_block  = req_data.block_number;
      job.first_offset = req_data.offset_number;
      job.delta        = delta;

      if (awaiting_ff) begin
         job.header  = 1'b1;
         prev_in     = value;
         count_in    = COUNT_W'(1);
         awaiting_in = 1'b0;
      end else if (!full_ff) begin
         if (value <= prev_ff) begin
            oerr = 1'b1;
         end else if (need <= {1'b0, budget}) begin
            job.nbytes    = len;
            bytes_used_in = need[BUDGET_W-1:0];
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + COUNT_W'(1);
            end
            prev_in = value;
         end else begin
            full_in = 1'b1;
         end
      end

      job.items       = count_in;
      job.bytes       = bytes_used_in;
      job.full        = full_in;
      job.order_error = oerr;
      job.summary     = req_data.end_of_list || oerr;
      job.pad         = req_data.end_of_list && bytes_used_in[0];

      if (req_data.end_of_list) begin
         prev_in       = '0;
         bytes_used_in = '0;
         count_in      = '0;
         awaiting_in   = 1'b1;
         full_in       = 1'b0;
      end
   end

   assign push = accept && (job.header || (job.nbytes != '0) || job.summary);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff       <= '0;
         bytes_used_ff <= '0;
         count_ff      <= '0;
         awaiting_ff   <= 1'b1;
         full_ff       <= 1'b0;
      end else if (accept) begin
         prev_ff       <= prev_in;
         bytes_used_ff <= bytes_used_in;
         count_ff      <= count_in;
         awaiting_ff   <= awaiting_in;
         full_ff       <= full_in;
      end
   end

   a_bytes_grow: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_data.end_of_list) |=> (bytes_used_ff >= $past(bytes_used_ff)))
      else $error("byte count fell within a list");

endmodule

`default_nettype wire

// ----- rtl/core/plve_fifo.sv -----
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module plve_fifo (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire plve_pkg::plve_job_type push_job,
   output      logic                   full,
   input  wire logic                   pop,
   output      logic                   head_valid,
   output      plve_pkg::plve_job_type head_job
);
   import plve_pkg::*;

   plve_job_type          slot_ff [FIFO_DEPTH];
   logic [FIFO_IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_IDX_W'(FIFO_DEPTH - 1)) ? '0
                                                                 : wr_ptr_ff + FIFO_IDX_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_IDX_W'(FIFO_DEPTH - 1)) ? '0
                                                                 : rd_ptr_ff + FIFO_IDX_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("job queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !head_valid))
      else $error("job queue read while empty");

endmodule

`default_nettype wire

// ----- rtl/core/plve_back.sv -----
// Back end: turns each job into its results, one per cycle while the output is not stalled, through an output register.
`timescale 1ns / 1ps
`default_nettype none

module plve_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   head_valid,
   input  wire plve_pkg::plve_job_type head_job,
   output      logic                   pop,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      plve_pkg::plve_rsp_type rsp_data
);
   import plve_pkg::*;

   plve_job_type cur_ff, cur_in, upd;
   logic         cur_valid_ff, cur_valid_in;
   logic         rsp_valid_ff, rsp_valid_in;
   plve_rsp_type rsp_data_ff, rsp_data_in;

   logic         out_free;
   logic         emit;
   logic         last;
   logic         load;
   plve_rsp_type result;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = cur_valid_ff && out_free;

   always_comb begin
      upd    = cur_ff;
      result = '0;
      if (cur_ff.header) begin
         result.kind         = KIND_HEADER;
         result.first_block  = cur_ff.first_block;
         result.first_offset = cur_ff.first_offset;
         upd.header          = 1'b0;
      end else if (cur_ff.nbytes != '0) begin
         result.kind      = KIND_DATA;
         result.data_byte = {cur_ff.nbytes != LEN_W'(1), cur_ff.delta[GROUP_BITS-1:0]};
         upd.nbytes       = cur_ff.nbytes - LEN_W'(1);
         upd.delta        = cur_ff.delta >> GROUP_BITS;
      end else if (cur_ff.pad) begin
         result.kind = KIND_PAD;
         upd.pad     = 1'b0;
      end else begin
         result.kind          = KIND_SUMMARY;
         result.items_packed  = cur_ff.items;
         result.bytes_written = cur_ff.bytes;
         result.segment_full  = cur_ff.full;
         result.order_error   = cur_ff.order_error;
         upd.summary          = 1'b0;
      end
      last               = !(upd.header || (upd.nbytes != '0) || upd.pad || upd.summary);
      result.last_of_run = last;
   end

   assign load = !cur_valid_ff || (emit && last);
   assign pop  = load && head_valid;

   always_comb begin
      cur_in       = emit ? upd : cur_ff;
      cur_valid_in = cur_valid_ff;
      if (load) begin
         cur_in       = head_job;
         cur_valid_in = head_valid;
      end
      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = emit ? result : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      (emit && (result.kind == KIND_SUMMARY)) |-> last)
      else $error("summary was not the final result of its request");

endmodule

`default_nettype wire

// ----- sim/plve_stream_checker.sv -----
// Checker that predicts the encoder's result stream and compares it with the block's output.
`timescale 1ns / 1ps

module plve_stream_checker
   import plve_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_stall,
   input  wire plve_req_type        req_data,
   input  wire logic                rsp_valid,
   input  wire logic                rsp_stall,
   input  wire plve_rsp_type        rsp_data,
   input  wire logic                csr_write_enable,
   input  wire logic [BUDGET_W-1:0] csr_write_data,
   output int                       fail_count,
   output int                       outstanding
);

   logic [BUDGET_W-1:0] budget;
   logic [VALUE_W-1:0]  last_value;
   int                  bytes_used;
   logic [COUNT_W-1:0]  items_in_list;
   bit                  awaiting_first;
   bit                  segment_full;
   int                  mismatches;
   plve_rsp_type        encoded_q[$];
   plve_rsp_type        wanted;

   initial begin
      mismatches  = 0;
   end

   task automatic clear_list();
      last_value     = '0;
      bytes_used     = 0;
      items_in_list  = '0;
      awaiting_first = 1'b1;
      segment_full   = 1'b0;
   endtask

   function automatic plve_rsp_type blank_result(input plve_kind_type kind);
      plve_rsp_type r;
      r      = '0;
      r.kind = kind;
      return r;
   endfunction

   function automatic plve_rsp_type list_summary(input bit order_error);
      plve_rsp_type r;
      r               = blank_result(KIND_SUMMARY);
      r.items_packed  = items_in_list;
      r.bytes_written = BUDGET_W'(bytes_used);
      r.segment_full  = segment_full;
      r.order_error   = order_error;
      return r;
   endfunction

   function automatic string describe(input plve_rsp_type r);
      return $sformatf({"kind=%0d byte=%02h block=%08h offset=%03h items=%0d bytes=%0d",
                        " full=%0b order=%0b last=%0b"},
                       r.kind, r.data_byte, r.first_block, r.first_offset, r.items_packed,
                       r.bytes_written, r.segment_full, r.order_error, r.last_of_run);
   endfunction

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   // Works out every result that one accepted request causes and queues them in order.
   task automatic encode_item(input plve_req_type item);
      logic [VALUE_W-1:0] value;
      logic [VALUE_W-1:0] delta;
      logic [VALUE_W-1:0] rest;
      int                 len;
      int                 queued_before;
      bit                 order_error;
      plve_rsp_type       r;
      queued_before = encoded_q.size();
      value         = {item.block_number, item.offset_number[OFFSET_BITS-1:0]};
      order_error   = 1'b0;
      if (awaiting_first) begin
         r              = blank_result(KIND_HEADER);
         r.first_block  = item.block_number;
         r.first_offset = item.offset_number;
         encoded_q.push_back(r);
         last_value     = value;
         items_in_list  = COUNT_W'(1);
         awaiting_first = 1'b0;
      end else if (!segment_full) begin
         if (value <= last_value) begin
            order_error = 1'b1;
         end else begin
            delta = value - last_value;
            rest  = delta;
            len   = 1;
            while (rest > 'h7F) begin
               rest = rest >> GROUP_BITS;
               len++;
            end
            if (bytes_used + len <= int'(budget)) begin
               rest = delta;
               while (rest > 'h7F) begin
                  r           = blank_result(KIND_DATA);
                  r.data_byte = {1'b1, rest[6:0]};
                  encoded_q.push_back(r);
                  rest = rest >> GROUP_BITS;
               end
               r           = blank_result(KIND_DATA);
               r.data_byte = rest[7:0];
               encoded_q.push_back(r);
               bytes_used += len;
               if (items_in_list != COUNT_MAX) begin
                  items_in_list++;
               end
               last_value = value;
            end else begin
               segment_full = 1'b1;
            end
         end
      end
      if (item.end_of_list) begin
         if (bytes_used % 2 == 1) begin
            encoded_q.push_back(blank_result(KIND_PAD));
         end
         encoded_q.push_back(list_summary(order_error));
         clear_list();
      end else if (order_error) begin
         encoded_q.push_back(list_summary(1'b1));
      end
      if (encoded_q.size() > queued_before) begin
         r             = encoded_q.pop_back();
         r.last_of_run = 1'b1;
         encoded_q.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         budget = BUDGET_RESET;
         clear_list();
         encoded_q.delete();
      end else begin
         if (csr_write_enable) begin
            budget = csr_write_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (encoded_q.size() == 0) begin
               note_mismatch({"result with nothing expected: ", describe(rsp_data)});
            end else begin
               wanted = encoded_q.pop_front();
               if (rsp_data !== wanted) begin
                  note_mismatch({"result mismatch: expected ", describe(wanted),
                                 " got ", describe(rsp_data)});
               end
            end
         end
         if (req_valid && !req_stall) begin
            encode_item(req_data);
         end
      end
      outstanding <= encoded_q.size();
      fail_count  <= mismatches;
   end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the posting list delta varbyte encoder: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_top;
   import plve_pkg::*;

   logic                clock;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_stall;
   plve_req_type        req_data         = '0;
   logic                rsp_valid;
   logic                rsp_stall        = 1'b0;
   plve_rsp_type        rsp_data;
   logic                csr_write_enable = 1'b0;
   logic [BUDGET_W-1:0] csr_write_data   = '0;
   int                  fail_count;
   int                  outstanding;
   int                  send_pct         = 0;
   int                  stall_pct        = 0;

   posting_list_delta_varbyte_encoder uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   plve_stream_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAIL posting_list_delta_varbyte_encoder");
      $finish;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic logic [VALUE_W-1:0] wide_random();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[VALUE_W-1:0];
   endfunction

   // Offers one request after a random idle gap and holds it until it is taken.
   task automatic present_item(input logic [VALUE_W-1:0] value, input bit eol);
      int           gap;
      plve_req_type item;
      gap = 0;
      while ($urandom_range(99) < send_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item.block_number  = value[VALUE_W-1:OFFSET_BITS];
      item.offset_number = value[OFFSET_BITS-1:0];
      item.end_of_list   = eol;
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic program_budget(input int value);
      wait_quiet();
      csr_write_enable <= 1'b1;
      csr_write_data   <= BUDGET_W'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Mostly rising lists with deltas of one to seven coded bytes, with some noise.
   task automatic random_lists(input int count);
      int                 sent;
      int                 len;
      int                 groups;
      logic [VALUE_W-1:0] value;
      logic [VALUE_W-1:0] step;
      sent = 0;
      while (sent < count) begin
         len   = $urandom_range(1, 10);
         if (len > count - sent) begin
            len = count - sent;
         end
         value = wide_random() >> $urandom_range(0, VALUE_W - 1);
         for (int i = 0; i < len; i++) begin
            if (i > 0) begin
               if ($urandom_range(7) == 0) begin
                  value = wide_random() >> $urandom_range(0, VALUE_W - 1);
               end else begin
                  groups = $urandom_range(1, 7);
                  step   = wide_random() & ((VALUE_W'(1) << (GROUP_BITS * groups)) - 1);
                  if (step == 0) begin
                     step = 1;
                  end
                  if (value > ~step) begin
                     value = value - $urandom_range(0, 3);
                  end else begin
                     value = value + step;
                  end
               end
            end
            present_item(value, i == len - 1);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      present_item('0, 1'b1);
      present_item('0, 1'b0);
      present_item({32'hFFFF_FFFF, 11'h7FF}, 1'b1);

      present_item(VALUE_W'(1000), 1'b0);
      present_item(VALUE_W'(1000 + 'h7F), 1'b0);
      present_item(VALUE_W'(1000 + 'h7F + 'h80), 1'b0);
      present_item(VALUE_W'(1000 + 'h7F + 'h80 + 'h3FFF), 1'b0);
      present_item(VALUE_W'(1000 + 'h7F + 'h80 + 'h3FFF + 'h4000), 1'b1);

      present_item(VALUE_W'(100), 1'b0);
      present_item(VALUE_W'(100), 1'b0);
      present_item(VALUE_W'(50), 1'b0);
      present_item(VALUE_W'(101), 1'b0);
      present_item(VALUE_W'(101), 1'b1);

      program_budget(2);
      present_item(VALUE_W'(0), 1'b0);
      present_item(VALUE_W'(200), 1'b0);
      present_item(VALUE_W'(201), 1'b0);
      present_item(VALUE_W'(150), 1'b0);
      present_item(VALUE_W'(300), 1'b1);

      // The budget is lowered below the bytes already used in the middle of a list.
      program_budget(3);
      present_item(VALUE_W'(7), 1'b0);
      present_item(VALUE_W'(8), 1'b0);
      program_budget(0);
      present_item(VALUE_W'(9), 1'b1);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_pct  = 0;
               stall_pct = 0;
               program_budget(8192);
            end
            1: begin
               send_pct  = 63;
               stall_pct = 0;
               program_budget($urandom_range(4, 24));
            end
            2: begin
               send_pct  = 0;
               stall_pct = 63;
               program_budget(1);
            end
            default: begin
               send_pct  = 15;
               stall_pct = 15;
               program_budget(8191);
            end
         endcase
         random_lists(32);
      end

      wait_quiet();
      if (fail_count == 0 && outstanding == 0) begin
         $display("PASS posting_list_delta_varbyte_encoder");
      end else begin
         $display("FAIL posting_list_delta_varbyte_encoder");
      end
      $finish;
   end

endmodule
